// ===== rtl/bcd_pkg.sv =====
// Shared types and constants for the button click event detector.
package bcd_pkg;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;

    // Reset values of the thresholds
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd3000;
    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd400;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_WAIT    = 2'd2,
        PH_LONG    = 2'd3
    } t_phase;

    typedef struct packed {
        logic               pressed;
        logic [STAMP_W-1:0] now_ms;
    } t_in_req;

    typedef struct packed {
        logic single_click;
        logic pair_click;
        logic hold_hit;
    } t_out_req;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hold_ms;
        logic [CFG_W-1:0] pair_window_ms;
    } t_cfg;

endpackage

// ===== rtl/bcd_cfg_regs.sv =====
// Threshold registers written through the plain configuration port.
module bcd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bcd_pkg::CFG_W-1:0]      i_cfg_wdata,
    output bcd_pkg::t_cfg                  o_cfg
);

    bcd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= bcd_pkg::DEBOUNCE_RST;
            r_cfg.hold_ms        <= bcd_pkg::LONG_RST;
            r_cfg.pair_window_ms <= bcd_pkg::WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bcd_pkg::REG_DEBOUNCE: r_cfg.debounce_ms    <= i_cfg_wdata;
                bcd_pkg::REG_LONG:     r_cfg.hold_ms        <= i_cfg_wdata;
                bcd_pkg::REG_WINDOW:   r_cfg.pair_window_ms <= i_cfg_wdata;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bcd_core.sv =====
// Click state machine: phase, stamps and flags, plus the pulse decode for one poll.
module bcd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  bcd_pkg::t_in_req  i_req,
    input  bcd_pkg::t_cfg     i_cfg,
    output bcd_pkg::t_out_req o_rsp
);

    bcd_pkg::t_phase                r_phase, n_phase;
    logic [bcd_pkg::STAMP_W-1:0]    r_press_stamp, n_press_stamp;
    logic [bcd_pkg::STAMP_W-1:0]    r_release_stamp, n_release_stamp;
    logic                           r_second_press, n_second_press;
    logic                           r_long_fired, n_long_fired;

    logic [bcd_pkg::STAMP_W-1:0]    held;
    logic [bcd_pkg::STAMP_W-1:0]    since;
    logic                           held_debounce;
    logic                           held_long;
    logic                           in_window;

    // wrapping elapsed times
    assign held  = i_req.now_ms - r_press_stamp;
    assign since = i_req.now_ms - r_release_stamp;

    assign held_debounce = held >= {{(bcd_pkg::STAMP_W-bcd_pkg::CFG_W){1'b0}}, i_cfg.debounce_ms};
    assign held_long     = held >= {{(bcd_pkg::STAMP_W-bcd_pkg::CFG_W){1'b0}}, i_cfg.hold_ms};
    assign in_window     = since <=
        {{(bcd_pkg::STAMP_W-bcd_pkg::CFG_W){1'b0}}, i_cfg.pair_window_ms};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= bcd_pkg::PH_IDLE;
            r_second_press <= 1'b0;
            r_long_fired   <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_second_press <= n_second_press;
            r_long_fired   <= n_long_fired;
        end
    end

    // stamps are only read in phases that write them first
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_press_stamp   <= n_press_stamp;
            r_release_stamp <= n_release_stamp;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_press_stamp   = r_press_stamp;
        n_release_stamp = r_release_stamp;
        n_second_press  = r_second_press;
        n_long_fired    = r_long_fired;
        o_rsp           = '0;
        case (r_phase)
            bcd_pkg::PH_IDLE: begin
                if (i_req.pressed) begin
                    n_phase       = bcd_pkg::PH_PRESSED;
                    n_press_stamp = i_req.now_ms;
                    n_long_fired  = 1'b0;
                end
            end
            bcd_pkg::PH_PRESSED: begin
                if (!i_req.pressed) begin
                    if (held_debounce && !r_long_fired) begin
                        if (r_second_press) begin
                            o_rsp.pair_click = 1'b1;
                            n_phase          = bcd_pkg::PH_IDLE;
                            n_second_press   = 1'b0;
                        end else begin
                            n_release_stamp = i_req.now_ms;
                            n_phase         = bcd_pkg::PH_WAIT;
                        end
                    end else begin
                        n_phase        = bcd_pkg::PH_IDLE;
                        n_second_press = 1'b0;
                    end
                end else if (held_long && !r_long_fired) begin
                    n_long_fired   = 1'b1;
                    o_rsp.hold_hit = 1'b1;
                    n_phase        = bcd_pkg::PH_LONG;
                end
            end
            bcd_pkg::PH_WAIT: begin
                if (i_req.pressed && in_window) begin
                    n_second_press = 1'b1;
                    n_press_stamp  = i_req.now_ms;
                    n_phase        = bcd_pkg::PH_PRESSED;
                end else if (!in_window) begin
                    // window ran out: single click, even with the button down
                    o_rsp.single_click = 1'b1;
                    n_phase            = bcd_pkg::PH_IDLE;
                    n_second_press     = 1'b0;
                end
            end
            bcd_pkg::PH_LONG: begin
                if (!i_req.pressed) begin
                    n_phase        = bcd_pkg::PH_IDLE;
                    n_second_press = 1'b0;
                end
            end
            default: begin
                n_phase        = bcd_pkg::PH_IDLE;
                n_second_press = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/button_click_event_detector_unit.sv =====
// Top level of the button click event detector: input register, click logic, result register.
//
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+------------------------------------------
//  in       | i_in_valid  | o_in_stall   | i_in_req  (pressed, now_ms)
//  out      | o_out_valid | i_out_stall  | o_out_req (single_click, pair_click, hold_hit)
//  cfg      | i_cfg_we    | none         | i_cfg_idx, i_cfg_wdata
//
// One poll per cycle sustained while the output is not stalled. A request is captured
// in the input register, runs through the phase logic and lands in the result register,
// loaded as it leaves the input. The phase state is updated when a request moves on.
// Reset (i_rst_n low, synchronous) empties both registers, returns to idle and loads
// the default thresholds (50, 3000, 400 ms). While reset is low the input is stalled.
// Out of reset the input stalls only when both registers are full and the output is stalled.
module button_click_event_detector_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // poll input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bcd_pkg::t_in_req              i_in_req,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bcd_pkg::t_out_req             o_out_req,
    // threshold writes
    input  logic                          i_cfg_we,
    input  logic [bcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcd_pkg::CFG_W-1:0]     i_cfg_wdata
);

    logic              r_in_valid;
    bcd_pkg::t_in_req  r_in_req;
    logic              r_out_valid;
    bcd_pkg::t_out_req r_out_req;

    logic              out_free;   // result register can take a new result
    logic              step;       // request in the input register is processed
    logic              in_take;
    bcd_pkg::t_cfg     cfg;
    bcd_pkg::t_out_req rsp;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = !i_rst_n || (r_in_valid && !out_free);
    assign in_take    = i_in_valid && !o_in_stall;

    bcd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bcd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in_req),
        .i_cfg   (cfg),
        .o_rsp   (rsp)
    );

    // input register: refills in the same cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req <= i_in_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_req <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

// ===== rtl/bcd_checker.sv =====
// Port-level checks for the button click event detector and their bind.
module bcd_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  bcd_pkg::t_out_req o_out_req
);

    // a poll never yields more than one event
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_out_req) <= 1))
        else $error("more than one click event in one result");

    // input backs up only when the result side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while result side could drain");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_req)))
        else $error("stalled result changed");

endmodule

bind button_click_event_detector_unit bcd_checker u_bcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);
